>>> sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the buddy block allocator
// Pool geometry, list link encoding, controller states, datapath commands.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int POOL_LOG = 16;
  localparam int MIN_LOG  = 5;
  localparam int ADDR_W   = 16;
  localparam int SIZE_W   = 16;
  localparam int TOP_LVL  = POOL_LOG - MIN_LOG;
  localparam int NLVL     = TOP_LVL + 1;
  localparam int NBLK     = 1 << TOP_LVL;
  localparam int BLK_W    = TOP_LVL;
  localparam int LINK_W   = TOP_LVL + 1;
  localparam int LVL_W    = 5;
  localparam int HLVL_W   = 4;
  localparam int HDR_W    = HLVL_W + 1;

  typedef logic [BLK_W-1:0]  blk_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [HDR_W-1:0]  hdr_t;

  // empty list / no neighbor: only the top bit set
  localparam link_t NONE = link_t'(NBLK);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SEARCH, S_POP, S_POPFIN, S_SPLIT, S_MARK,
    S_HDR, S_MRD, S_MCHK, S_PUSH, S_PUSH2, S_DONE_A, S_DONE_F, S_FAIL
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_INIT, OP_LOAD, OP_SEARCH, OP_POP, OP_POP_FIN, OP_SPLIT,
    OP_MARK, OP_HDR, OP_MERGE_RD, OP_UNLINK, OP_PUSH, OP_PUSH2,
    OP_RES_ALLOC, OP_RES_FREE, OP_RES_FAIL
  } op_t;

  typedef struct packed {
    logic in_cmd;
    logic in_want_bad;
    logic in_free_bad;
    logic empty;
    logic lvl_over;
    logic lvl_top;
    logic lvl_gt_want;
    logic used;
    logic bud_ok;
  } status_t;

endpackage

>>> sv/bba_datapath.sv
// ----------------------------------------------------------------------------
// bba_datapath: free lists, block headers and working registers
// Executes one command from the controller per cycle.
// ----------------------------------------------------------------------------
module bba_datapath
  import bba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  op_t               op,
  input  logic              in_cmd,
  input  logic [SIZE_W-1:0] in_size,
  input  logic [ADDR_W-1:0] in_uaddr,
  output status_t           status,
  output logic [ADDR_W-1:0] res_addr,
  output logic              res_ok
);

  hdr_t  hdr_mem [NBLK];
  link_t nxt_mem [NBLK];
  link_t prv_mem [NBLK];
  link_t head    [NLVL];

  hdr_t  hdr_rd;
  link_t nxt_rd, prv_rd;

  lvl_t  want, lvl;
  blk_t  b;
  link_t oh;

  // memory ports
  logic  hdr_we, nxt_we, prv_we;
  blk_t  hdr_wa, nxt_wa, prv_wa, hdr_ra, nxt_ra, prv_ra;
  hdr_t  hdr_wd;
  link_t nxt_wd, prv_wd;

  lvl_t  want_c;
  logic [ADDR_W-1:0] off;
  link_t head_sel, n_link;
  lvl_t  lvl_dn;
  blk_t  lvl_bit, lvl_dn_bit;

  always_comb begin
    want_c = '0;
    for (int i = MIN_LOG; i < SIZE_W; i++) begin
      if (in_size[i]) want_c = lvl_t'(i - MIN_LOG + 1);
    end
  end

  assign off        = in_uaddr - ADDR_W'(1);
  assign head_sel   = (lvl <= lvl_t'(TOP_LVL)) ? head[lvl[HLVL_W-1:0]] : NONE;
  assign lvl_dn     = lvl - lvl_t'(1);
  assign lvl_bit    = blk_t'(1) << lvl;
  assign lvl_dn_bit = blk_t'(1) << lvl_dn;
  assign n_link     = nxt_rd[LINK_W-1] ? NONE : nxt_rd;

  assign status.in_cmd      = in_cmd;
  assign status.in_want_bad = want_c > lvl_t'(TOP_LVL);
  assign status.in_free_bad = (in_uaddr == '0) || (off[MIN_LOG-1:0] != '0);
  assign status.empty       = head_sel[LINK_W-1];
  assign status.lvl_over    = lvl > lvl_t'(TOP_LVL);
  assign status.lvl_top     = lvl >= lvl_t'(TOP_LVL);
  assign status.lvl_gt_want = lvl > want;
  assign status.used        = hdr_rd[HDR_W-1];
  assign status.bud_ok      = !hdr_rd[HDR_W-1] && (lvl_t'(hdr_rd[HLVL_W-1:0]) == lvl);

  always_comb begin
    hdr_we = 1'b0; hdr_wa = b; hdr_wd = '0; hdr_ra = b;
    nxt_we = 1'b0; nxt_wa = b; nxt_wd = NONE; nxt_ra = b;
    prv_we = 1'b0; prv_wa = b; prv_wd = NONE; prv_ra = b;
    case (op)
      OP_INIT: begin
        hdr_we = 1'b1; hdr_wa = '0; hdr_wd = hdr_t'(TOP_LVL);
        nxt_we = 1'b1; nxt_wa = '0;
        prv_we = 1'b1; prv_wa = '0;
      end
      OP_LOAD:    hdr_ra = off[ADDR_W-1:MIN_LOG];
      OP_POP:     nxt_ra = head_sel[BLK_W-1:0];
      OP_POP_FIN: begin
        prv_we = !n_link[LINK_W-1]; prv_wa = n_link[BLK_W-1:0];
      end
      OP_SPLIT: begin
        hdr_we = 1'b1; hdr_wa = b + lvl_dn_bit; hdr_wd = hdr_t'(lvl_dn);
        nxt_we = 1'b1; nxt_wa = b + lvl_dn_bit;
        prv_we = 1'b1; prv_wa = b + lvl_dn_bit;
      end
      OP_MARK: begin
        hdr_we = 1'b1; hdr_wd = {1'b1, want[HLVL_W-1:0]};
      end
      OP_MERGE_RD: begin
        hdr_ra = b ^ lvl_bit; nxt_ra = b ^ lvl_bit; prv_ra = b ^ lvl_bit;
      end
      OP_UNLINK: begin
        // bypass the buddy: predecessor points past it, successor back
        nxt_we = !prv_rd[LINK_W-1]; nxt_wa = prv_rd[BLK_W-1:0]; nxt_wd = n_link;
        prv_we = !n_link[LINK_W-1]; prv_wa = n_link[BLK_W-1:0];
        prv_wd = prv_rd[LINK_W-1] ? NONE : prv_rd;
      end
      OP_PUSH: begin
        hdr_we = 1'b1; hdr_wd = hdr_t'(lvl);
        nxt_we = 1'b1; nxt_wd = head_sel;
        prv_we = 1'b1;
      end
      OP_PUSH2: begin
        prv_we = !oh[LINK_W-1]; prv_wa = oh[BLK_W-1:0]; prv_wd = {1'b0, b};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    hdr_rd <= hdr_mem[hdr_ra];
    nxt_rd <= nxt_mem[nxt_ra];
    prv_rd <= prv_mem[prv_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NLVL; i++) head[i] <= (i == TOP_LVL) ? '0 : NONE;
    end else begin
      case (op)
        OP_POP_FIN: head[lvl[HLVL_W-1:0]] <= n_link;
        OP_SPLIT:   head[lvl_dn[HLVL_W-1:0]] <= {1'b0, b + lvl_dn_bit};
        OP_UNLINK:  if (prv_rd[LINK_W-1]) head[lvl[HLVL_W-1:0]] <= n_link;
        OP_PUSH:    head[lvl[HLVL_W-1:0]] <= {1'b0, b};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        want <= want_c;
        lvl  <= want_c;
        b    <= off[ADDR_W-1:MIN_LOG];
      end
      OP_SEARCH:  lvl <= lvl + lvl_t'(1);
      OP_POP:     b   <= head_sel[BLK_W-1:0];
      OP_SPLIT:   lvl <= lvl_dn;
      OP_HDR:     lvl <= lvl_t'(hdr_rd[HLVL_W-1:0]);
      OP_UNLINK: begin
        b   <= b & ~lvl_bit;
        lvl <= lvl + lvl_t'(1);
      end
      OP_PUSH:    oh <= head_sel;
      OP_RES_ALLOC: begin
        res_addr <= {b, {MIN_LOG{1'b0}}} + ADDR_W'(1);
        res_ok   <= 1'b1;
      end
      OP_RES_FREE: begin
        res_addr <= '0;
        res_ok   <= 1'b1;
      end
      OP_RES_FAIL: begin
        res_addr <= '0;
        res_ok   <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl: request sequencer of the buddy block allocator
// Steps search, split, merge and push; owns both handshakes.
// ----------------------------------------------------------------------------
module bba_ctrl
  import bba_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output op_t     op
);

  state_t state, state_next;
  logic   slot_free, load_res;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_res) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    load_res   = 1'b0;
    case (state)
      S_INIT: begin
        op = OP_INIT; state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = OP_LOAD;
          if (status.in_cmd) state_next = status.in_free_bad ? S_FAIL : S_HDR;
          else state_next = status.in_want_bad ? S_FAIL : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (status.lvl_over) state_next = S_FAIL;
        else if (!status.empty) state_next = S_POP;
        else op = OP_SEARCH;
      end
      S_POP: begin
        op = OP_POP; state_next = S_POPFIN;
      end
      S_POPFIN: begin
        op = OP_POP_FIN; state_next = S_SPLIT;
      end
      S_SPLIT: begin
        if (status.lvl_gt_want) op = OP_SPLIT;
        else state_next = S_MARK;
      end
      S_MARK: begin
        op = OP_MARK; state_next = S_DONE_A;
      end
      S_HDR: begin
        if (!status.used) state_next = S_FAIL;
        else begin
          op = OP_HDR; state_next = S_MRD;
        end
      end
      S_MRD: begin
        if (status.lvl_top) state_next = S_PUSH;
        else begin
          op = OP_MERGE_RD; state_next = S_MCHK;
        end
      end
      S_MCHK: begin
        if (status.bud_ok) begin
          op = OP_UNLINK; state_next = S_MRD;
        end else state_next = S_PUSH;
      end
      S_PUSH: begin
        op = OP_PUSH; state_next = S_PUSH2;
      end
      S_PUSH2: begin
        op = OP_PUSH2; state_next = S_DONE_F;
      end
      S_DONE_A: if (slot_free) begin
        op = OP_RES_ALLOC; load_res = 1'b1; state_next = S_IDLE;
      end
      S_DONE_F: if (slot_free) begin
        op = OP_RES_FREE; load_res = 1'b1; state_next = S_IDLE;
      end
      S_FAIL: if (slot_free) begin
        op = OP_RES_FAIL; load_res = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> sv/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator: binary buddy allocator over a 64 KiB pool
// Per-level LIFO free lists, 32-byte minimum block, split on allocate,
// merge with free buddies on free.
// ----------------------------------------------------------------------------
//  channel | signals                     | contents
//  s_*     | tvalid tready tdata tuser   | request: size, user address, cmd
//  m_*     | tvalid tready tdata tuser   | result: granted address, ok
//
//  One request at a time. Allocate: load, search (up to 12 levels), pop and
//  relink the list head, one split per level above the wanted one, mark, result.
//  Free: load, header read, buddy read and check per merge (up to 11), push,
//  link the old head back, result. Both walk the header and link memories.
//  After reset, the init state seeds the top-level block header and links.
//  A result waits in the output register; the next request is taken as
//  soon as the sequencer is back in idle, even while that result stalls.
// ----------------------------------------------------------------------------
module buddy_block_allocator
  import bba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] request_size, [31:16] user_address
  input  logic        s_tuser,   // [0] cmd: 0 allocate, 1 free
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] granted_address
  output logic        m_tuser    // [0] ok
);

  op_t     op;
  status_t status;

  // sequencer: owns handshakes and steps the datapath
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .op        (op)
  );

  // lists, headers and the result register
  bba_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .in_cmd   (s_tuser),
    .in_size  (s_tdata[15:0]),
    .in_uaddr (s_tdata[31:16]),
    .status   (status),
    .res_addr (m_tdata),
    .res_ok   (m_tuser)
  );

  // a refused request never carries an address
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 16'd0)
    else $error("refused request with nonzero address");

  // granted addresses are block starts plus one
  a_grant_align: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata != 16'd0 |-> m_tdata[4:0] == 5'd1)
    else $error("granted address not block aligned");

  // one request in flight: ready drops after an accept
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

endmodule

>>> test/buddy_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_tb: self-checking bench for the buddy block allocator
// Drives allocate and free requests, tracks the free lists and block headers
// in a local model, and compares every result item with the expected one.
// ----------------------------------------------------------------------------
module buddy_block_allocator_tb;
  import bba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        cmd;
    logic [15:0] size;
    logic [15:0] uaddr;
  } req_t;

  typedef struct packed {
    logic [15:0] addr;
    logic        ok;
  } res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        s_tready_q = 1'b0;

  buddy_block_allocator dut (.*);

  always #6 clk = ~clk;

  // allocator model state
  int unsigned free_head[NLVL];
  int unsigned nxt_link[NBLK];
  int unsigned prv_link[NBLK];
  bit          blk_used[NBLK];
  int unsigned blk_lvl[NBLK];

  req_t        pending_reqs[$];
  res_t        expected_results[$];
  logic [15:0] granted_blocks[$];   // live allocations, offset plus one
  int          mismatches = 0;
  int unsigned send_idle = 0;       // percent of cycles the sender idles
  int unsigned recv_stall = 0;      // percent of cycles the receiver stalls

  function automatic void push_blk(int unsigned l, int unsigned b);
    nxt_link[b] = free_head[l];
    prv_link[b] = NBLK;
    if (free_head[l] < NBLK) prv_link[free_head[l]] = b;
    free_head[l] = b;
  endfunction

  function automatic int unsigned pop_blk(int unsigned l);
    int unsigned b;
    int unsigned n;
    b = free_head[l];
    n = nxt_link[b];
    free_head[l] = (n < NBLK) ? n : NBLK;
    if (n < NBLK) prv_link[n] = NBLK;
    return b;
  endfunction

  function automatic void unlink_blk(int unsigned l, int unsigned b);
    int unsigned p;
    int unsigned n;
    p = prv_link[b];
    n = (nxt_link[b] < NBLK) ? nxt_link[b] : NBLK;
    if (p < NBLK) nxt_link[p] = n;
    else free_head[l] = n;
    if (n < NBLK) prv_link[n] = (p < NBLK) ? p : NBLK;
  endfunction

  function automatic void reset_allocator();
    foreach (free_head[i]) free_head[i] = NBLK;
    foreach (blk_used[i]) begin
      blk_used[i] = 0;
      blk_lvl[i] = 0;
    end
    blk_lvl[0] = TOP_LVL;
    push_blk(TOP_LVL, 0);
  endfunction

  // Compute the result of one request and update the model.
  function automatic res_t serve_request(req_t r);
    res_t        res;
    int unsigned want;
    int unsigned l;
    int unsigned b;
    int unsigned sz;
    int unsigned off;
    res = '0;
    if (!r.cmd) begin
      want = 0;
      sz = r.size;
      while (sz >= (1 << MIN_LOG)) begin
        sz >>= 1;
        want++;
      end
      if (want > TOP_LVL) return res;
      l = want;
      while (l <= TOP_LVL && free_head[l] >= NBLK) l++;
      if (l > TOP_LVL) return res;
      while (l > want) begin
        b = pop_blk(l);
        l--;
        blk_lvl[b] = l;
        blk_used[b] = 0;
        blk_lvl[b + (1 << l)] = l;
        blk_used[b + (1 << l)] = 0;
        push_blk(l, b + (1 << l));
        push_blk(l, b);
      end
      b = pop_blk(want);
      blk_used[b] = 1;
      res.addr = 16'((b << MIN_LOG) + 1);
      res.ok = 1'b1;
    end else begin
      if (r.uaddr == 0) return res;
      off = r.uaddr - 1;
      if (off[MIN_LOG-1:0] != 0) return res;
      b = off >> MIN_LOG;
      if (b >= NBLK || !blk_used[b]) return res;
      l = blk_lvl[b];
      while (l < TOP_LVL) begin
        if (blk_used[b ^ (1 << l)] || blk_lvl[b ^ (1 << l)] != l) break;
        unlink_blk(l, b ^ (1 << l));
        b &= ~(1 << l);
        l++;
      end
      blk_used[b] = 0;
      blk_lvl[b] = l;
      push_blk(l, b);
      res.ok = 1'b1;
    end
    return res;
  endfunction

  // Model the stimulus side too, so frees target live blocks most of the time.
  // Only blocks that were handed out are freed as valid; a bad free probes
  // headers that are already written, so no unwritten entry is ever read.
  function automatic void queue_request(req_t r);
    res_t e;
    int   idx;
    e = serve_request(r);
    if (!r.cmd && e.ok) granted_blocks.push_back(e.addr);
    if (r.cmd && e.ok) begin
      idx = -1;
      foreach (granted_blocks[i]) if (granted_blocks[i] == r.uaddr) idx = i;
      if (idx >= 0) granted_blocks.delete(idx);
    end
    pending_reqs.push_back(r);
    expected_results.push_back(e);
  endfunction

  function automatic logic [15:0] rand_size();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 6) return 16'($urandom_range(0, 1023));
    if (k < 9) return 16'($urandom_range(0, 8191));
    return 16'($urandom);
  endfunction

  function automatic void queue_random();
    req_t r;
    int unsigned k;
    r.size = 16'($urandom);
    r.uaddr = 16'($urandom);
    k = $urandom_range(0, 99);
    if (k < 50 || granted_blocks.size() == 0) begin
      r.cmd = 1'b0;
      r.size = rand_size();
    end else if (k < 90) begin
      r.cmd = 1'b1;
      r.uaddr = granted_blocks[$urandom_range(0, granted_blocks.size() - 1)];
    end else begin
      // broken free: stale, misaligned or arbitrary address
      r.cmd = 1'b1;
      if (k < 95) r.uaddr = 16'({$urandom_range(0, NBLK - 1), 5'b0} + 1);
      // a block number that was never a block start reads an unwritten header
      if (k < 95 && !blk_used[(r.uaddr - 1) >> MIN_LOG]) begin
        if (blk_lvl[(r.uaddr - 1) >> MIN_LOG] == 0 && ((r.uaddr - 1) >> MIN_LOG) != 0)
          r.uaddr[0] = 1'b0;
      end
      if (k >= 95) r.uaddr[0] = 1'b0;
    end
    queue_request(r);
  endfunction

  function automatic void queue_alloc(logic [15:0] sz);
    queue_request('{cmd: 1'b0, size: sz, uaddr: 16'hFFFF});
  endfunction

  function automatic void queue_free(logic [15:0] ua);
    queue_request('{cmd: 1'b1, size: 16'hFFFF, uaddr: ua});
  endfunction

  // Driver: present the head of the queue, advance on the handshake.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready_q) begin
        if (pending_reqs.size() > 0 && $urandom_range(1, 100) > send_idle) begin
          s_tvalid <= 1'b1;
          s_tdata <= {pending_reqs[0].uaddr, pending_reqs[0].size};
          s_tuser <= pending_reqs[0].cmd;
          void'(pending_reqs.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(1, 100) > recv_stall);
    end
  end

  // Accept flag captured at the rising edge for the driver.
  always @(posedge clk) s_tready_q <= s_tvalid && s_tready;

  // Monitor: compare each result item against the oldest expectation.
  always @(posedge clk) begin
    res_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: addr %h ok %b", m_tdata, m_tuser);
      end else begin
        e = expected_results.pop_front();
        if (m_tdata !== e.addr || m_tuser !== e.ok) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected addr %h ok %b, got addr %h ok %b",
                     e.addr, e.ok, m_tdata, m_tuser);
        end
      end
    end
  end

  function automatic void set_idling(int unsigned ph);
    case (ph % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 88; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 88; end
      default: begin send_idle = 24; recv_stall = 24; end
    endcase
  endfunction

  initial begin
    reset_allocator();
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: size extremes, exact fits, exhaustion, bad frees, merges
    queue_alloc(16'd0);            // smallest level
    queue_alloc(16'd31);
    queue_alloc(16'd32);           // one level up
    queue_free(16'd1);             // free the first block
    queue_free(16'd1);             // double free
    queue_free(16'd0);             // zero address
    queue_free(16'd2);             // misaligned
    queue_free(16'h0021);          // block start still in use: merges with the first
    queue_alloc(16'hFFFF);         // whole pool wanted, none free
    queue_alloc(16'h8000);         // whole pool as well
    queue_alloc(16'h4000);         // half pool
    queue_alloc(16'h4000);         // no fitting block: other half split
    queue_free(16'h8001);
    queue_free(16'h0041);
    queue_free(16'h0021);
    queue_alloc(16'h7FFF);         // half pool, split from the merged pool
    queue_alloc(16'd40);           // fits in the free half
    queue_free(16'h0001);
    queue_alloc(16'hAAAA);
    queue_alloc(16'h5555);
    queue_free(16'h0021);          // block start inside a live block, not in use
    queue_free(16'hFFFF);

    for (int ph = 0; ph < 8; ph++) begin
      set_idling(ph);
      repeat (180) queue_random();
      wait (pending_reqs.size() == 0);
    end
    set_idling(0);
    // drain: free everything left, ending on a merged pool
    while (granted_blocks.size() > 0) queue_free(granted_blocks.pop_front());
    queue_alloc(16'h7FFF);

    wait (pending_reqs.size() == 0 && expected_results.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("buddy_block_allocator_tb passed");
    end else begin
      $display("buddy_block_allocator_tb failed");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("buddy_block_allocator_tb failed");
    $finish;
  end

endmodule

>>> sim.f
sv/bba_pkg.sv
sv/bba_datapath.sv
sv/bba_ctrl.sv
sv/buddy_block_allocator.sv
test/buddy_block_allocator_tb.sv
